>>> rtl/cbr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_pkg
// Shared sizes, codes and the command struct of the cursor bitmap converter.
// ----------------------------------------------------------------------------
package cbr_pkg;

  localparam int MAX_WIDTH       = 64;
  localparam int MAX_HEIGHT      = 64;
  localparam int PALETTE_ENTRIES = 256;

  localparam int PIX_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int MASK_DEPTH = (PIX_DEPTH + 7) / 8;
  localparam int PIX_AW     = $clog2(PIX_DEPTH);
  localparam int MASK_AW    = $clog2(MASK_DEPTH);
  localparam int PAL_AW     = $clog2(PALETTE_ENTRIES);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);

  // register field width and the width that holds any clamped dimension
  localparam int CFG_DIM_W = 7;
  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_W     = ($clog2(MAX_DIM + 1) > CFG_DIM_W) ?
                             $clog2(MAX_DIM + 1) : CFG_DIM_W;
  localparam int PROD_W    = ROW_W + DIM_W;

  localparam logic [CFG_DIM_W-1:0] RESET_WIDTH  = 7'd32;
  localparam logic [CFG_DIM_W-1:0] RESET_HEIGHT = 7'd32;
  localparam logic [7:0]           ALPHA_OPAQUE = 8'd255;

  typedef enum logic [1:0] {
    OP_PALETTE = 2'd0,
    OP_COLOUR  = 2'd1,
    OP_MASK    = 2'd2,
    OP_READ    = 2'd3
  } cbr_op_e;

  typedef enum logic [1:0] {
    CFG_COLOR_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cbr_cfg_e;

  typedef struct packed {
    logic               pal_we;
    logic               pix_we;
    logic [PIX_AW-1:0]  pix_waddr;
    logic               mask_we;
    logic [MASK_AW-1:0] mask_waddr;
    logic               rd_en;
    logic [PIX_AW-1:0]  rd_pix;
    logic               last;
  } cbr_cmd_t;

endpackage
`default_nettype wire

>>> rtl/cbr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_ram
// Simple dual-port synchronous RAM, read-first, registered read data.
// ----------------------------------------------------------------------------
module cbr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // hold the last read word while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

>>> rtl/cbr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cbr_ctrl
// Configuration registers, store write pointers and the read position;
// turns each accepted request into store writes or a pixel read address.
// ----------------------------------------------------------------------------
module cbr_ctrl (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [1:0]                       cfg_addr_i,
  input  wire logic [cbr_pkg::CFG_DIM_W-1:0]    cfg_data_i,
  input  wire logic                             accept_i,
  input  wire logic [1:0]                       operation_i,
  input  wire logic [7:0]                       entry_index_i,
  output logic                                  color_mode_o,
  output cbr_pkg::cbr_cmd_t                     cmd_o
);
  import cbr_pkg::*;

  logic                 mode_q, mode_d;
  logic [CFG_DIM_W-1:0] width_q, width_d;
  logic [CFG_DIM_W-1:0] height_q, height_d;
  logic [PIX_AW-1:0]    pix_ptr_q, pix_ptr_d;
  logic [MASK_AW-1:0]   mask_ptr_q, mask_ptr_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic                 rewind_q, rewind_d;

  logic [DIM_W-1:0]  w_eff, h_eff, w_ext, h_ext;
  logic              rewind;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [PROD_W-1:0] prod;
  logic              col_end;

  // clamp the dimensions to 1..MAX
  always_comb begin
    w_ext = DIM_W'(width_q);
    h_ext = DIM_W'(height_q);
    if (width_q == '0) begin
      w_eff = DIM_W'(1);
    end else if (w_ext > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    if (height_q == '0) begin
      h_eff = DIM_W'(1);
    end else if (h_ext > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = h_ext;
    end
  end

  // a pending rewind or an out-of-range position starts at the bottom stored row
  assign rewind  = rewind_q || (DIM_W'(row_q) >= h_eff) || (DIM_W'(col_q) >= w_eff);
  assign cur_row = rewind ? ROW_W'(h_eff - DIM_W'(1)) : row_q;
  assign cur_col = rewind ? '0 : col_q;
  assign prod    = PROD_W'(cur_row) * PROD_W'(w_eff) + PROD_W'(cur_col);
  assign col_end = (DIM_W'(cur_col) + DIM_W'(1)) >= w_eff;

  always_comb begin
    mode_d     = mode_q;
    width_d    = width_q;
    height_d   = height_q;
    pix_ptr_d  = pix_ptr_q;
    mask_ptr_d = mask_ptr_q;
    col_d      = col_q;
    row_d      = row_q;
    rewind_d   = rewind_q;

    cmd_o            = '0;
    cmd_o.pix_waddr  = pix_ptr_q;
    cmd_o.mask_waddr = mask_ptr_q;
    cmd_o.rd_pix     = prod[PIX_AW-1:0];

    if (cfg_we_i) begin
      case (cfg_addr_i)
        CFG_COLOR_MODE: begin
          mode_d   = cfg_data_i[0];
          rewind_d = 1'b1;
        end
        CFG_IMAGE_WIDTH: begin
          width_d  = cfg_data_i;
          rewind_d = 1'b1;
        end
        CFG_IMAGE_HEIGHT: begin
          height_d = cfg_data_i;
          rewind_d = 1'b1;
        end
        default: ;
      endcase
    end

    if (accept_i) begin
      case (operation_i)
        OP_PALETTE: begin
          cmd_o.pal_we = ({1'b0, entry_index_i} < 9'(PALETTE_ENTRIES));
        end
        OP_COLOUR: begin
          cmd_o.pix_we = 1'b1;
          pix_ptr_d = (pix_ptr_q == PIX_AW'(PIX_DEPTH - 1)) ? '0 : pix_ptr_q + 1'b1;
        end
        OP_MASK: begin
          cmd_o.mask_we = 1'b1;
          mask_ptr_d = (mask_ptr_q == MASK_AW'(MASK_DEPTH - 1)) ? '0 : mask_ptr_q + 1'b1;
        end
        OP_READ: begin
          cmd_o.rd_en = 1'b1;
          rewind_d    = 1'b0;
          if (col_end) begin
            col_d = '0;
            if (cur_row == '0) begin
              // final pixel: rewind everything
              cmd_o.last = 1'b1;
              pix_ptr_d  = '0;
              mask_ptr_d = '0;
              rewind_d   = 1'b1;
              row_d      = cur_row;
            end else begin
              row_d = cur_row - 1'b1;
            end
          end else begin
            col_d = cur_col + 1'b1;
            row_d = cur_row;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      width_q    <= RESET_WIDTH;
      height_q   <= RESET_HEIGHT;
      pix_ptr_q  <= '0;
      mask_ptr_q <= '0;
      col_q      <= '0;
      row_q      <= '0;
      rewind_q   <= 1'b1;
    end else begin
      mode_q     <= mode_d;
      width_q    <= width_d;
      height_q   <= height_d;
      pix_ptr_q  <= pix_ptr_d;
      mask_ptr_q <= mask_ptr_d;
      col_q      <= col_d;
      row_q      <= row_d;
      rewind_q   <= rewind_d;
    end
  end

  assign color_mode_o = mode_q;

  a_read_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.rd_en |-> !(cmd_o.pix_we || cmd_o.mask_we || cmd_o.pal_we))
    else $error("read request drives a store write");

  a_last_rewinds_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.rd_en && cmd_o.last) |=> (pix_ptr_q == '0 && mask_ptr_q == '0 && rewind_q))
    else $error("final pixel did not rewind pointers");

  a_cfg_rewinds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && (cfg_addr_i == CFG_COLOR_MODE || cfg_addr_i == CFG_IMAGE_WIDTH ||
                  cfg_addr_i == CFG_IMAGE_HEIGHT)) |=> rewind_q)
    else $error("register write did not rewind read position");

endmodule
`default_nettype wire

>>> rtl/cursor_bitmap_to_rgba.sv
// ----------------------------------------------------------------------------
// cursor_bitmap_to_rgba
// An accepted read request reads its pixel word and mask byte, then the
// palette entry, each from a RAM with registered read data. Throughput:
// one request per cycle while the result is taken.
// Reset: registers go to colour_mode 0, 32 x 32, pointers to zero, read
// position to the bottom stored row; the stores are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
module cursor_bitmap_to_rgba (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [1:0]                    cfg_addr_i,
  input  wire logic [cbr_pkg::CFG_DIM_W-1:0] cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [1:0]                    operation_i,
  input  wire logic [7:0]                    entry_index_i,
  input  wire logic [31:0]                   payload_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic      [7:0]                    red_o,
  output logic      [7:0]                    green_o,
  output logic      [7:0]                    blue_o,
  output logic      [7:0]                    alpha_o,
  output logic                               last_pixel_o
);
  import cbr_pkg::*;

  cbr_cmd_t    cmd;
  logic        color_mode;
  logic        advance, accept;
  logic [31:0] pix_word;
  logic [7:0]  mask_byte;
  logic [23:0] pal_bgr;

  logic        s1_valid_q;
  logic [2:0]  s1_bit_q;
  logic        s1_last_q;
  logic        s2_valid_q;
  logic [31:0] s2_word_q;
  logic        s2_masked_q;
  logic        s2_idx_ok_q;
  logic        s2_last_q;

  logic [23:0] bgr;

  assign advance    = !s2_valid_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  cbr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .entry_index_i (entry_index_i),
    .color_mode_o  (color_mode),
    .cmd_o         (cmd)
  );

  cbr_ram #(.WIDTH(32), .DEPTH(PIX_DEPTH), .AW(PIX_AW)) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.pix_we),
    .waddr_i (cmd.pix_waddr),
    .wdata_i (payload_i),
    .re_i    (cmd.rd_en),
    .raddr_i (cmd.rd_pix),
    .rdata_o (pix_word)
  );

  cbr_ram #(.WIDTH(8), .DEPTH(MASK_DEPTH), .AW(MASK_AW)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.mask_we),
    .waddr_i (cmd.mask_waddr),
    .wdata_i (payload_i[7:0]),
    .re_i    (cmd.rd_en),
    .raddr_i (MASK_AW'(cmd.rd_pix >> 3)),
    .rdata_o (mask_byte)
  );

  // read-first: a palette write alongside an earlier request's lookup is not seen
  cbr_ram #(.WIDTH(24), .DEPTH(PALETTE_ENTRIES), .AW(PAL_AW)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (cmd.pal_we),
    .waddr_i (entry_index_i[PAL_AW-1:0]),
    .wdata_i (payload_i[23:0]),
    .re_i    (advance && s1_valid_q),
    .raddr_i (pix_word[PAL_AW-1:0]),
    .rdata_o (pal_bgr)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= cmd.rd_en;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_bit_q    <= cmd.rd_pix[2:0];
      s1_last_q   <= cmd.last;
      s2_word_q   <= pix_word;
      s2_masked_q <= mask_byte[3'd7 - s1_bit_q];
      s2_idx_ok_q <= ({1'b0, pix_word[7:0]} < 9'(PALETTE_ENTRIES));
      s2_last_q   <= s1_last_q;
    end
  end

  always_comb begin
    if (color_mode) begin
      bgr     = s2_word_q[23:0];
      alpha_o = s2_word_q[31:24];
    end else begin
      bgr     = s2_idx_ok_q ? pal_bgr : '0;
      alpha_o = ALPHA_OPAQUE;
    end
    if (s2_masked_q) begin
      alpha_o = '0;
    end
    blue_o  = bgr[7:0];
    green_o = bgr[15:8];
    red_o   = bgr[23:16];
  end

  assign out_valid_o  = s2_valid_q;
  assign last_pixel_o = s2_valid_q && s2_last_q;

  a_read_enters_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && operation_i == OP_READ) |=> s1_valid_q)
    else $error("accepted read request lost before stage one");

  a_s1_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !advance) |=> s1_valid_q)
    else $error("stage one dropped a request under stall");

  a_s2_from_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(s2_valid_q) |-> $past(s1_valid_q))
    else $error("result appeared without a request in stage one");

endmodule
`default_nettype wire
